// ===== hw/rtl/bcts_pkg.sv =====
// ----------------------------------------------------------------------------
// bcts_pkg: shared definitions for the backoff count table scorer
// Table geometry, fixed-point constants, result codes and the command and
// status bundles passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package bcts_pkg;

  // Table geometry. All six tables have the same depth.
  localparam int unsigned TBL_ENTRIES = 256;
  localparam int unsigned IDX_W       = $clog2(TBL_ENTRIES);
  localparam int unsigned FILL_W      = IDX_W + 1;
  localparam int unsigned NUM_TBL     = 6;

  // Table numbers, in the order the fill levels are kept.
  localparam int unsigned TBL_TRI = 0;  // source-event-target
  localparam int unsigned TBL_SE  = 1;  // source-event
  localparam int unsigned TBL_ST  = 2;  // source-target
  localparam int unsigned TBL_S   = 3;  // source
  localparam int unsigned TBL_ET  = 4;  // event-target
  localparam int unsigned TBL_E   = 5;  // event

  // Key width of each table.
  localparam int unsigned KEY_W [NUM_TBL] = '{96, 64, 64, 32, 64, 32};
  localparam int unsigned KEY_MAX_W = 96;

  // Operation codes.
  localparam logic OP_OBSERVE = 1'b0;
  localparam logic OP_SCORE   = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_FLOOR    = 1'b0;
  localparam logic CFG_DISCOUNT = 1'b1;

  // Reported backoff levels.
  localparam logic [2:0] LVL_OBS = 3'd0;
  localparam logic [2:0] LVL_TRI = 3'd1;
  localparam logic [2:0] LVL_SRC = 3'd2;
  localparam logic [2:0] LVL_EVT = 3'd3;
  localparam logic [2:0] LVL_DEF = 3'd4;
  localparam logic [2:0] LVL_INV = 3'd5;

  // Fixed log results in Q5.10.
  localparam logic [15:0] LOG_INVALID = 16'hD800;  // -10.0
  localparam logic [15:0] LOG_DEFAULT = 16'hE000;  // -8.0
  localparam logic [15:0] LOG_MIN     = 16'h8000;  // -32.0

  // ln(2) in Q0.28.
  localparam logic [27:0] LN2_Q28 = 28'd186065280;

  // Reset values of the configuration registers.
  localparam logic [31:0] FLOOR_RST    = 32'd1;
  localparam logic [15:0] DISCOUNT_RST = 16'd26214;

  // Log unit operand selects.
  localparam logic [1:0] LG_C = 2'd0;
  localparam logic [1:0] LG_T = 2'd1;
  localparam logic [1:0] LG_D = 2'd2;

  // Controller to datapath commands.
  typedef struct packed {
    logic       load;
    logic       scan_run;
    logic       pick;
    logic       commit;
    logic       lg_start;
    logic [1:0] lg_sel;
    logic       sum;
    logic       mul;
    logic       finish;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic scan_done;
    logic obs;
    logic drop;
    logic need_log;
    logic k_nz;
    logic lg_done;
  } sts_t;

  // Saturating count increment.
  function automatic logic [31:0] sat_inc(input logic [31:0] c);
    sat_inc = (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

endpackage

// ===== hw/rtl/backoff_count_table_scorer_top.sv =====
// ----------------------------------------------------------------------------
// backoff_count_table_scorer_top: backoff n-gram count table scorer
// Records observations into six count tables and scores queries with
// three-level stupid backoff as a Q5.10 natural log.
// ----------------------------------------------------------------------------
// One item is handled at a time. Every item first scans the six tables in
// parallel, one entry per cycle, over as many entries as the fullest table
// holds (up to 256), then drains the read pipeline. Level selection, routing
// and the result hand-over follow, which is all that an invalid or unmatched
// query goes through. An observation that is not dropped also updates the
// tables before the hand-over. A scored query that fires a level and needs a
// logarithm runs two or three of them on the shared log unit, then a sum
// step and a scaling step. The table scan sets the rate as the tables fill.
// The next item is taken in the cycle after a result is handed over, even
// while that result still waits at the output.
// ----------------------------------------------------------------------------
module backoff_count_table_scorer_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  logic [31:0]        source_type_i,
  input  logic [31:0]        event_hash_i,
  input  logic               event_present_i,
  input  logic [31:0]        target_type_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] log_prob_o,
  output logic [2:0]         level_o,
  output logic               dropped_o
);

  bcts_pkg::cmd_t cmd;
  bcts_pkg::sts_t sts;

  // Sequencing.
  bcts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Tables and arithmetic.
  bcts_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .operation_i     (operation_i),
    .source_type_i   (source_type_i),
    .event_hash_i    (event_hash_i),
    .event_present_i (event_present_i),
    .target_type_i   (target_type_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .log_prob_o      (log_prob_o),
    .level_o         (level_o),
    .dropped_o       (dropped_o)
  );

endmodule

// ===== hw/rtl/bcts_log2.sv =====
// ----------------------------------------------------------------------------
// bcts_log2: iterative base-2 logarithm
// Returns log2(x) in Q.24 for x >= 1: a five-step normalizing shift gives the
// integer part, then 24 squarings of the Q1.31 mantissa give the fraction.
// ----------------------------------------------------------------------------
module bcts_log2 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] x_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [28:0] res_o
);

  logic        busy_q, busy_d;
  logic        norm_q, norm_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] y_q, y_d;
  logic [4:0]  n_q, n_d;
  logic [23:0] frac_q, frac_d;
  logic [4:0]  sh;
  logic        top_zero;
  logic [63:0] sq;
  logic [32:0] sq_top;

  // Shift amount for the current normalizing step: 16, 8, 4, 2, 1.
  assign sh       = 5'd16 >> cnt_q[2:0];
  assign top_zero = (y_q >> (6'd32 - {1'b0, sh})) == 32'd0;

  // Mantissa square, rescaled to Q1.31 with one bit of headroom.
  assign sq     = y_q * y_q;
  assign sq_top = sq[63:31];

  // Sequencer: normalize first, then square once per fraction bit.
  always_comb begin
    busy_d = busy_q;
    norm_d = norm_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    y_d    = y_q;
    n_d    = n_q;
    frac_d = frac_q;
    if (start_i) begin
      busy_d = 1'b1;
      norm_d = 1'b1;
      cnt_d  = 5'd0;
      y_d    = x_i;
      n_d    = 5'd31;
      frac_d = 24'd0;
    end else if (busy_q && norm_q) begin
      if (top_zero) begin
        y_d = y_q << sh;
        n_d = n_q - sh;
      end
      if (cnt_q == 5'd4) begin
        norm_d = 1'b0;
        cnt_d  = 5'd0;
      end else begin
        cnt_d = cnt_q + 5'd1;
      end
    end else if (busy_q) begin
      y_d    = sq_top[32] ? sq_top[32:1] : sq_top[31:0];
      frac_d = {frac_q[22:0], sq_top[32]};
      if (cnt_q == 5'd23) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 5'd1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      norm_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      busy_q <= busy_d;
      norm_q <= norm_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Working values.
  always_ff @(posedge clk_i) begin
    y_q    <= y_d;
    n_q    <= n_d;
    frac_q <= frac_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign res_o  = {n_q, frac_q};

  // Once normalized, the mantissa keeps its top bit set through every squaring.
  a_norm_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !norm_q |-> y_q[31])
    else $error("log2 mantissa lost normalization");

endmodule

// ===== hw/rtl/bcts_dpath.sv =====
// ----------------------------------------------------------------------------
// bcts_dpath: tables, lookup scan and score arithmetic
// Holds the six count tables, scans them in parallel one entry per cycle,
// updates them on observations and forms the Q5.10 log score on queries.
// ----------------------------------------------------------------------------
module bcts_dpath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               operation_i,
  input  logic [31:0]        source_type_i,
  input  logic [31:0]        event_hash_i,
  input  logic               event_present_i,
  input  logic [31:0]        target_type_i,
  input  bcts_pkg::cmd_t     cmd_i,
  output bcts_pkg::sts_t     sts_o,
  output logic signed [15:0] log_prob_o,
  output logic [2:0]         level_o,
  output logic               dropped_o
);

  // Configuration registers.
  logic [31:0] floor_q;
  logic [15:0] disc_q;

  // Latched item.
  logic        op_q;
  logic        pres_q;
  logic [31:0] src_q, evt_q, tgt_q;
  logic        item_ok;
  logic [bcts_pkg::KEY_MAX_W-1:0] probe_key [bcts_pkg::NUM_TBL];

  // Scan pipeline.
  logic [bcts_pkg::FILL_W-1:0] scan_addr_q, cmp_idx_q, max_fill;
  logic                        rd_vld_q, scan_issue;

  // Per-table lookup results.
  logic                        found [bcts_pkg::NUM_TBL];
  logic [31:0]                 cnt   [bcts_pkg::NUM_TBL];
  logic [bcts_pkg::FILL_W-1:0] fill  [bcts_pkg::NUM_TBL];
  logic                        full;

  // Score selection.
  logic        f1, f2, f3;
  logic [31:0] c_sel, t_sel, c_clamp;
  logic [1:0]  k_sel;
  logic [31:0] c_q, t_q;
  logic [1:0]  k_q;
  logic [2:0]  lvl_q, lvl_d;
  logic        special_q, special_d, drop_q, need_log_q;

  // Log arithmetic.
  logic        lg_busy, lg_done;
  logic [28:0] lg_res, lc_q, lt_q, ld_q;
  logic [1:0]  cur_sel_q;
  logic [31:0] lg_x;
  logic signed [32:0] dd, kterm, v, neg_v;
  logic [31:0] m_q;
  logic [59:0] prod_q, rnd;
  logic [17:0] r;
  logic [16:0] mag, mag_neg;
  logic [15:0] log_val;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= bcts_pkg::FLOOR_RST;
      disc_q  <= bcts_pkg::DISCOUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bcts_pkg::CFG_FLOOR:    floor_q <= cfg_data_i;
        bcts_pkg::CFG_DISCOUNT: disc_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Input transaction capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= operation_i;
      pres_q <= event_present_i;
      src_q  <= source_type_i;
      evt_q  <= event_hash_i;
      tgt_q  <= target_type_i;
    end
  end

  assign item_ok = (src_q != 32'd0) && (tgt_q != 32'd0) && pres_q;

  // Probe keys, right-aligned in a common width.
  always_comb begin
    probe_key[bcts_pkg::TBL_TRI] = {src_q, evt_q, tgt_q};
    probe_key[bcts_pkg::TBL_SE]  = {32'd0, src_q, evt_q};
    probe_key[bcts_pkg::TBL_ST]  = {32'd0, src_q, tgt_q};
    probe_key[bcts_pkg::TBL_S]   = {64'd0, src_q};
    probe_key[bcts_pkg::TBL_ET]  = {32'd0, evt_q, tgt_q};
    probe_key[bcts_pkg::TBL_E]   = {64'd0, evt_q};
  end

  // Scan length is the largest fill level; emptier tables ignore late entries.
  always_comb begin
    max_fill = '0;
    full     = 1'b0;
    for (int i = 0; i < bcts_pkg::NUM_TBL; i++) begin
      if (fill[i] > max_fill) max_fill = fill[i];
      if (!found[i] && fill[i] == bcts_pkg::FILL_W'(bcts_pkg::TBL_ENTRIES)) full = 1'b1;
    end
  end

  assign scan_issue = cmd_i.scan_run && (scan_addr_q < max_fill);

  // Scan address and read-compare pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_addr_q <= '0;
      cmp_idx_q   <= '0;
      rd_vld_q    <= 1'b0;
    end else if (cmd_i.load) begin
      scan_addr_q <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      rd_vld_q  <= scan_issue;
      cmp_idx_q <= scan_addr_q;
      if (scan_issue) scan_addr_q <= scan_addr_q + 1'b1;
    end
  end

  // One table per block: memory, fill level and lookup result.
  for (genvar g = 0; g < bcts_pkg::NUM_TBL; g++) begin : g_tbl
    localparam int unsigned KW = bcts_pkg::KEY_W[g];

    logic [KW+31:0]              mem_q [bcts_pkg::TBL_ENTRIES];
    logic [KW+31:0]              rd_q;
    logic [bcts_pkg::FILL_W-1:0] fill_q;
    logic                        found_q;
    logic [bcts_pkg::IDX_W-1:0]  hit_q, wr_addr;
    logic [31:0]                 cnt_q;
    logic                        hit_now;

    assign hit_now = rd_vld_q && !found_q && (cmp_idx_q < fill_q) &&
                     (rd_q[KW+31:32] == probe_key[g][KW-1:0]);
    assign wr_addr = found_q ? hit_q : fill_q[bcts_pkg::IDX_W-1:0];

    // Table storage: scan read and observation write.
    always_ff @(posedge clk_i) begin
      if (scan_issue) rd_q <= mem_q[scan_addr_q[bcts_pkg::IDX_W-1:0]];
      if (cmd_i.commit) begin
        mem_q[wr_addr] <= {probe_key[g][KW-1:0],
                           found_q ? bcts_pkg::sat_inc(cnt_q) : 32'd1};
      end
    end

    // Fill level and hit flag.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        fill_q  <= '0;
        found_q <= 1'b0;
      end else begin
        if (cmd_i.load) found_q <= 1'b0;
        else if (hit_now) found_q <= 1'b1;
        if (cmd_i.commit && !found_q) fill_q <= fill_q + 1'b1;
      end
    end

    // Hit location and stored count.
    always_ff @(posedge clk_i) begin
      if (hit_now) begin
        hit_q <= cmp_idx_q[bcts_pkg::IDX_W-1:0];
        cnt_q <= rd_q[31:0];
      end
    end

    assign found[g] = found_q;
    assign cnt[g]   = cnt_q;
    assign fill[g]  = fill_q;
  end

  // Backoff level selection.
  assign f1 = found[bcts_pkg::TBL_TRI] && found[bcts_pkg::TBL_SE] &&
              (cnt[bcts_pkg::TBL_SE] >= floor_q);
  assign f2 = found[bcts_pkg::TBL_ST] && found[bcts_pkg::TBL_S] &&
              (cnt[bcts_pkg::TBL_S] >= floor_q);
  assign f3 = found[bcts_pkg::TBL_ET] && found[bcts_pkg::TBL_E] &&
              (cnt[bcts_pkg::TBL_E] >= floor_q);

  always_comb begin
    c_sel = cnt[bcts_pkg::TBL_ET];
    t_sel = cnt[bcts_pkg::TBL_E];
    k_sel = 2'd2;
    lvl_d = bcts_pkg::LVL_DEF;
    if (op_q == bcts_pkg::OP_OBSERVE) begin
      lvl_d = bcts_pkg::LVL_OBS;
    end else if (!item_ok) begin
      lvl_d = bcts_pkg::LVL_INV;
    end else if (f1) begin
      c_sel = cnt[bcts_pkg::TBL_TRI];
      t_sel = cnt[bcts_pkg::TBL_SE];
      k_sel = 2'd0;
      lvl_d = bcts_pkg::LVL_TRI;
    end else if (f2) begin
      c_sel = cnt[bcts_pkg::TBL_ST];
      t_sel = cnt[bcts_pkg::TBL_S];
      k_sel = 2'd1;
      lvl_d = bcts_pkg::LVL_SRC;
    end else if (f3) begin
      lvl_d = bcts_pkg::LVL_EVT;
    end
    // A count above its total scores as a ratio of one.
    c_clamp   = (c_sel > t_sel) ? t_sel : c_sel;
    special_d = (c_clamp == 32'd0) || ((k_sel != 2'd0) && (disc_q == 16'd0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_q     <= 1'b0;
      need_log_q <= 1'b0;
      lvl_q      <= bcts_pkg::LVL_OBS;
    end else if (cmd_i.pick) begin
      drop_q     <= !item_ok || full;
      need_log_q <= (lvl_d == bcts_pkg::LVL_TRI || lvl_d == bcts_pkg::LVL_SRC ||
                     lvl_d == bcts_pkg::LVL_EVT) && !special_d;
      lvl_q      <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pick) begin
      c_q       <= c_clamp;
      t_q       <= t_sel;
      k_q       <= k_sel;
      special_q <= special_d;
    end
  end

  // Shared log unit.
  always_comb begin
    case (cmd_i.lg_sel)
      bcts_pkg::LG_C: lg_x = c_q;
      bcts_pkg::LG_T: lg_x = t_q;
      default:        lg_x = {16'd0, disc_q};
    endcase
  end

  bcts_log2 u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.lg_start),
    .x_i     (lg_x),
    .busy_o  (lg_busy),
    .done_o  (lg_done),
    .res_o   (lg_res)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.lg_start) cur_sel_q <= cmd_i.lg_sel;
    if (lg_done) begin
      case (cur_sel_q)
        bcts_pkg::LG_C: lc_q <= lg_res;
        bcts_pkg::LG_T: lt_q <= lg_res;
        default:        ld_q <= lg_res;
      endcase
    end
  end

  // Sum in Q.24, clamp to at most zero, then scale by ln(2).
  assign dd    = $signed({4'd0, ld_q}) - 33'sd268435456;
  assign kterm = k_q[1] ? (dd <<< 1) : (k_q[0] ? dd : 33'sd0);
  assign v     = $signed({4'd0, lc_q}) - $signed({4'd0, lt_q}) + kterm;
  assign neg_v = -v;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) m_q    <= v[32] ? neg_v[31:0] : 32'd0;
    if (cmd_i.mul) prod_q <= m_q * bcts_pkg::LN2_Q28;
  end

  // Round to Q10, ties away from zero, and saturate.
  assign rnd     = prod_q + (60'd1 << 41);
  assign r       = rnd[59:42];
  assign mag     = (r > 18'd32768) ? 17'd32768 : r[16:0];
  assign mag_neg = 17'd0 - mag;

  always_comb begin
    if (lvl_q == bcts_pkg::LVL_OBS)      log_val = 16'd0;
    else if (lvl_q == bcts_pkg::LVL_INV) log_val = bcts_pkg::LOG_INVALID;
    else if (lvl_q == bcts_pkg::LVL_DEF) log_val = bcts_pkg::LOG_DEFAULT;
    else if (special_q)                  log_val = bcts_pkg::LOG_MIN;
    else                                 log_val = mag_neg[15:0];
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      log_prob_o <= log_val;
      level_o    <= lvl_q;
      dropped_o  <= (lvl_q == bcts_pkg::LVL_OBS) && drop_q;
    end
  end

  assign sts_o.scan_done = !scan_issue && !rd_vld_q;
  assign sts_o.obs       = (op_q == bcts_pkg::OP_OBSERVE);
  assign sts_o.drop      = drop_q;
  assign sts_o.need_log  = need_log_q;
  assign sts_o.k_nz      = (k_q != 2'd0);
  assign sts_o.lg_done   = lg_done;

  // A table is only written when the observation is not dropped.
  a_commit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !drop_q)
    else $error("table write on a dropped observation");

  // The log unit is never restarted while it is still working.
  a_lg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.lg_start |-> !lg_busy)
    else $error("log unit started while busy");

  // Fill levels never pass the table depth.
  a_fill_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    max_fill <= bcts_pkg::FILL_W'(bcts_pkg::TBL_ENTRIES))
    else $error("table fill level overflow");

endmodule

// ===== hw/rtl/bcts_ctrl.sv =====
// ----------------------------------------------------------------------------
// bcts_ctrl: sequencing state machine
// Steps each item through scan, table update or log evaluation, and owns the
// input and output handshakes.
// ----------------------------------------------------------------------------
module bcts_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  bcts_pkg::sts_t sts_i,
  output bcts_pkg::cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_PICK  = 4'd2;
  localparam logic [3:0] S_ROUTE = 4'd3;
  localparam logic [3:0] S_WRITE = 4'd4;
  localparam logic [3:0] S_LC    = 4'd5;
  localparam logic [3:0] S_LT    = 4'd6;
  localparam logic [3:0] S_LD    = 4'd7;
  localparam logic [3:0] S_SUM   = 4'd8;
  localparam logic [3:0] S_MUL   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.lg_sel = bcts_pkg::LG_C;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (sts_i.scan_done) state_d = S_PICK;
      end
      S_PICK: begin
        cmd_o.pick = 1'b1;
        state_d    = S_ROUTE;
      end
      S_ROUTE: begin
        if (sts_i.obs) begin
          state_d = sts_i.drop ? S_DONE : S_WRITE;
        end else if (sts_i.need_log) begin
          cmd_o.lg_start = 1'b1;
          state_d        = S_LC;
        end else begin
          state_d = S_DONE;
        end
      end
      S_WRITE: begin
        cmd_o.commit = 1'b1;
        state_d      = S_DONE;
      end
      S_LC: begin
        if (sts_i.lg_done) begin
          cmd_o.lg_start = 1'b1;
          cmd_o.lg_sel   = bcts_pkg::LG_T;
          state_d        = S_LT;
        end
      end
      S_LT: begin
        if (sts_i.lg_done) begin
          if (sts_i.k_nz) begin
            cmd_o.lg_start = 1'b1;
            cmd_o.lg_sel   = bcts_pkg::LG_D;
            state_d        = S_LD;
          end else begin
            state_d = S_SUM;
          end
        end
      end
      S_LD: begin
        if (sts_i.lg_done) state_d = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DONE;
      end
      S_DONE: begin
        // Hand the result over once the output register is free.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== test/backoff_count_table_scorer_top_test.sv =====
// ----------------------------------------------------------------------------
// backoff_count_table_scorer_top_test: testbench for the backoff scorer
// Drives observe and score transactions with random gaps on both sides and
// compares each result with a scoreboard kept by a local model of the six
// count tables, the backoff walk and the fixed-point logarithm.
// ----------------------------------------------------------------------------
module backoff_count_table_scorer_top_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = bcts_pkg::TBL_ENTRIES;

  typedef struct {
    logic        op;
    logic [31:0] src;
    logic [31:0] evt;
    logic        pres;
    logic [31:0] tgt;
  } query_t;

  typedef struct packed {
    logic [15:0] lp;
    logic [2:0]  lvl;
    logic        drop;
  } score_t;

  typedef struct {
    query_t q;
    bit     typed;
    score_t r;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        operation_i;
  logic [31:0] source_type_i;
  logic [31:0] event_hash_i;
  logic        event_present_i;
  logic [31:0] target_type_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic signed [15:0] log_prob_o;
  logic [2:0]  level_o;
  logic        dropped_o;

  backoff_count_table_scorer_top uut (.*);

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Model copy of the registers and count tables.
  logic [31:0] floor_q;
  logic [15:0] disc_q;
  logic [31:0] tri_src [DEPTH], tri_evt [DEPTH], tri_tgt [DEPTH], tri_cnt [DEPTH];
  logic [31:0] se_src [DEPTH], se_evt [DEPTH], se_cnt [DEPTH];
  logic [31:0] st_src [DEPTH], st_tgt [DEPTH], st_cnt [DEPTH];
  logic [31:0] s_key [DEPTH], s_cnt [DEPTH];
  logic [31:0] et_evt [DEPTH], et_tgt [DEPTH], et_cnt [DEPTH];
  logic [31:0] e_key [DEPTH], e_cnt [DEPTH];
  int unsigned fill [6];

  score_t expected_scores[$];
  int     error_count = 0;
  int     results_seen = 0;
  logic [31:0] src_pool [8], evt_pool [8], tgt_pool [8];
  row_t   rows[$];

  function automatic logic [31:0] bump(input logic [31:0] c);
    return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

  // Returns -1 when the key is absent.
  function automatic int find2(input logic [31:0] ka [DEPTH], input logic [31:0] kb [DEPTH],
                               input int unsigned n, input logic [31:0] a,
                               input logic [31:0] b);
    for (int i = 0; i < n; i++) if (ka[i] == a && kb[i] == b) return i;
    return -1;
  endfunction

  function automatic int find1(input logic [31:0] ka [DEPTH], input int unsigned n,
                               input logic [31:0] a);
    for (int i = 0; i < n; i++) if (ka[i] == a) return i;
    return -1;
  endfunction

  function automatic int find_tri(input logic [31:0] s, input logic [31:0] e,
                                  input logic [31:0] t);
    for (int i = 0; i < fill[bcts_pkg::TBL_TRI]; i++)
      if (tri_src[i] == s && tri_evt[i] == e && tri_tgt[i] == t) return i;
    return -1;
  endfunction

  function automatic int slot(input int found, input int unsigned n);
    if (found >= 0) return found;
    return (n < DEPTH) ? int'(n) : -1;
  endfunction

  // log2 in Q.24 by repeated squaring of the normalized mantissa.
  function automatic longint log2_q24(input logic [31:0] x);
    int          n;
    logic [63:0] y;
    logic [31:0] frac;
    n = 31;
    frac = '0;
    while (n > 0 && x[n] == 1'b0) n--;
    y = 64'(x) << (31 - n);
    for (int i = 0; i < 24; i++) begin
      y = (y * y) >> 31;
      frac = frac << 1;
      if (y >= 64'h1_0000_0000) begin
        y = y >> 1;
        frac[0] = 1'b1;
      end
    end
    return (longint'(n) <<< 24) + longint'(frac);
  endfunction

  // ln(c / t * d^k) in Q5.10, rounded half away from zero.
  function automatic logic [15:0] ln_ratio(input logic [31:0] c, input logic [31:0] t,
                                           input int k);
    longint      v;
    logic [63:0] m, r;
    if (c > t) c = t;
    if (c == 0 || (k != 0 && disc_q == 0)) return bcts_pkg::LOG_MIN;
    v = log2_q24(c) - log2_q24(t);
    if (k != 0) v += longint'(k) * (log2_q24({16'd0, disc_q}) - (longint'(16) <<< 24));
    if (v > 0) v = 0;
    m = 64'(-v);
    r = (m * 64'd186065280 + (64'd1 << 41)) >> 42;
    if (r > 64'd32768) r = 64'd32768;
    return 16'(-r);
  endfunction

  // Applies one transaction to the model tables and returns its result.
  function automatic score_t predict_score(input query_t q);
    score_t res;
    bit     ok;
    int     a, b, c, d, e, f;
    ok = q.src != 0 && q.tgt != 0 && q.pres;
    res = '{lp: 16'd0, lvl: bcts_pkg::LVL_OBS, drop: 1'b0};
    if (q.op == bcts_pkg::OP_OBSERVE) begin
      res.drop = 1'b1;
      if (!ok) return res;
      a = slot(find_tri(q.src, q.evt, q.tgt), fill[bcts_pkg::TBL_TRI]);
      b = slot(find2(se_src, se_evt, fill[bcts_pkg::TBL_SE], q.src, q.evt),
               fill[bcts_pkg::TBL_SE]);
      c = slot(find2(st_src, st_tgt, fill[bcts_pkg::TBL_ST], q.src, q.tgt),
               fill[bcts_pkg::TBL_ST]);
      d = slot(find1(s_key, fill[bcts_pkg::TBL_S], q.src), fill[bcts_pkg::TBL_S]);
      e = slot(find2(et_evt, et_tgt, fill[bcts_pkg::TBL_ET], q.evt, q.tgt),
               fill[bcts_pkg::TBL_ET]);
      f = slot(find1(e_key, fill[bcts_pkg::TBL_E], q.evt), fill[bcts_pkg::TBL_E]);
      if (a < 0 || b < 0 || c < 0 || d < 0 || e < 0 || f < 0) return res;
      if (a == fill[bcts_pkg::TBL_TRI]) begin
        tri_src[a] = q.src; tri_evt[a] = q.evt; tri_tgt[a] = q.tgt; tri_cnt[a] = 0;
        fill[bcts_pkg::TBL_TRI]++;
      end
      tri_cnt[a] = bump(tri_cnt[a]);
      if (b == fill[bcts_pkg::TBL_SE]) begin
        se_src[b] = q.src; se_evt[b] = q.evt; se_cnt[b] = 0; fill[bcts_pkg::TBL_SE]++;
      end
      se_cnt[b] = bump(se_cnt[b]);
      if (c == fill[bcts_pkg::TBL_ST]) begin
        st_src[c] = q.src; st_tgt[c] = q.tgt; st_cnt[c] = 0; fill[bcts_pkg::TBL_ST]++;
      end
      st_cnt[c] = bump(st_cnt[c]);
      if (d == fill[bcts_pkg::TBL_S]) begin
        s_key[d] = q.src; s_cnt[d] = 0; fill[bcts_pkg::TBL_S]++;
      end
      s_cnt[d] = bump(s_cnt[d]);
      if (e == fill[bcts_pkg::TBL_ET]) begin
        et_evt[e] = q.evt; et_tgt[e] = q.tgt; et_cnt[e] = 0; fill[bcts_pkg::TBL_ET]++;
      end
      et_cnt[e] = bump(et_cnt[e]);
      if (f == fill[bcts_pkg::TBL_E]) begin
        e_key[f] = q.evt; e_cnt[f] = 0; fill[bcts_pkg::TBL_E]++;
      end
      e_cnt[f] = bump(e_cnt[f]);
      res.drop = 1'b0;
      return res;
    end
    if (!ok) return '{lp: bcts_pkg::LOG_INVALID, lvl: bcts_pkg::LVL_INV, drop: 1'b0};
    a = find_tri(q.src, q.evt, q.tgt);
    b = find2(se_src, se_evt, fill[bcts_pkg::TBL_SE], q.src, q.evt);
    if (a >= 0 && b >= 0 && se_cnt[b] >= floor_q)
      return '{lp: ln_ratio(tri_cnt[a], se_cnt[b], 0), lvl: bcts_pkg::LVL_TRI, drop: 1'b0};
    c = find2(st_src, st_tgt, fill[bcts_pkg::TBL_ST], q.src, q.tgt);
    d = find1(s_key, fill[bcts_pkg::TBL_S], q.src);
    if (c >= 0 && d >= 0 && s_cnt[d] >= floor_q)
      return '{lp: ln_ratio(st_cnt[c], s_cnt[d], 1), lvl: bcts_pkg::LVL_SRC, drop: 1'b0};
    e = find2(et_evt, et_tgt, fill[bcts_pkg::TBL_ET], q.evt, q.tgt);
    f = find1(e_key, fill[bcts_pkg::TBL_E], q.evt);
    if (e >= 0 && f >= 0 && e_cnt[f] >= floor_q)
      return '{lp: ln_ratio(et_cnt[e], e_cnt[f], 2), lvl: bcts_pkg::LVL_EVT, drop: 1'b0};
    return '{lp: bcts_pkg::LOG_DEFAULT, lvl: bcts_pkg::LVL_DEF, drop: 1'b0};
  endfunction

  // Random gap length: mostly short, now and then long.
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 15);
  endfunction

  // Random transaction; fresh keys fill the tables, pool keys build counts.
  function automatic query_t rand_query(input bit fresh, input int score_pct);
    query_t q;
    q.op = ($urandom_range(99) < score_pct) ? bcts_pkg::OP_SCORE : bcts_pkg::OP_OBSERVE;
    if (fresh) begin
      q.src = $urandom; q.evt = $urandom; q.tgt = $urandom;
      if (q.src == 0) q.src = 32'd1;
      if (q.tgt == 0) q.tgt = 32'd1;
    end else begin
      q.src = src_pool[$urandom_range(7)];
      q.evt = evt_pool[$urandom_range(7)];
      q.tgt = tgt_pool[$urandom_range(7)];
    end
    q.pres = 1'b1;
    case ($urandom_range(19))
      0: q.src = '0;
      1: q.tgt = '0;
      2: q.pres = 1'b0;
      default: ;
    endcase
    return q;
  endfunction

  function automatic row_t mk(input logic op, input logic [31:0] s, input logic [31:0] e,
                              input logic p, input logic [31:0] t, input bit typed,
                              input logic [15:0] lp, input logic [2:0] lvl,
                              input logic drop);
    row_t r;
    r.q = '{op: op, src: s, evt: e, pres: p, tgt: t};
    r.typed = typed;
    r.r = '{lp: lp, lvl: lvl, drop: drop};
    return r;
  endfunction

  // Register write at the falling edge, mirrored into the model.
  task automatic write_reg(input logic idx, input logic [31:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == bcts_pkg::CFG_FLOOR) floor_q = val;
    else disc_q = val[15:0];
  endtask

  task automatic set_phase(input logic [31:0] flr, input logic [15:0] dsc);
    wait (expected_scores.size() == 0);
    @(negedge clk_i);
    write_reg(bcts_pkg::CFG_FLOOR, flr);
    write_reg(bcts_pkg::CFG_DISCOUNT, {16'd0, dsc});
  endtask

  // Offers one transaction and holds it until accepted.
  task automatic send(input query_t q, input bit typed, input score_t typed_res);
    score_t res;
    repeat (gap_len()) @(negedge clk_i);
    in_valid_i = 1'b1;
    operation_i = q.op;
    source_type_i = q.src;
    event_hash_i = q.evt;
    event_present_i = q.pres;
    target_type_i = q.tgt;
    do @(posedge clk_i); while (!in_ready_o);
    res = predict_score(q);
    expected_scores.push_back(typed ? typed_res : res);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Result side: random back-pressure with one long hold-off.
  initial begin
    bit held;
    held = 0;
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && results_seen >= 120) begin
        held = 1;
        out_ready_i = 1'b0;
        repeat (3000) @(negedge clk_i);
      end
      out_ready_i = (gap_len() == 0);
    end
  end

  // Result checking against the oldest expectation.
  always @(posedge clk_i) begin
    score_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_scores.size() == 0) begin
        $error("unexpected result transaction");
        error_count++;
      end else begin
        want = expected_scores.pop_front();
        if (log_prob_o !== want.lp) begin
          $error("log_prob expected %0d got %0d", $signed(want.lp), log_prob_o);
          error_count++;
        end
        if (level_o !== want.lvl) begin
          $error("level expected %0d got %0d", want.lvl, level_o);
          error_count++;
        end
        if (dropped_o !== want.drop) begin
          $error("dropped expected %0d got %0d", want.drop, dropped_o);
          error_count++;
        end
      end
    end
  end

  // Run limit.
  initial begin
    #8_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Main stimulus.
  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = bcts_pkg::CFG_FLOOR;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    operation_i = bcts_pkg::OP_OBSERVE;
    source_type_i = '0;
    event_hash_i = '0;
    event_present_i = 1'b0;
    target_type_i = '0;
    floor_q = bcts_pkg::FLOOR_RST;
    disc_q = bcts_pkg::DISCOUNT_RST;
    foreach (fill[i]) fill[i] = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed rows at the reset settings.
    rows.push_back(mk(bcts_pkg::OP_SCORE, 1, 1, 1, 1, 1,
                      bcts_pkg::LOG_DEFAULT, bcts_pkg::LVL_DEF, 0));
    rows.push_back(mk(bcts_pkg::OP_SCORE, 0, 1, 1, 1, 1,
                      bcts_pkg::LOG_INVALID, bcts_pkg::LVL_INV, 0));
    rows.push_back(mk(bcts_pkg::OP_SCORE, 1, 1, 1, 0, 1,
                      bcts_pkg::LOG_INVALID, bcts_pkg::LVL_INV, 0));
    rows.push_back(mk(bcts_pkg::OP_SCORE, 1, 1, 0, 1, 1,
                      bcts_pkg::LOG_INVALID, bcts_pkg::LVL_INV, 0));
    rows.push_back(mk(bcts_pkg::OP_OBSERVE, 0, 1, 1, 1, 1, 16'd0, bcts_pkg::LVL_OBS, 1));
    rows.push_back(mk(bcts_pkg::OP_OBSERVE, 1, 1, 1, 0, 1, 16'd0, bcts_pkg::LVL_OBS, 1));
    rows.push_back(mk(bcts_pkg::OP_OBSERVE, 1, 1, 0, 1, 1, 16'd0, bcts_pkg::LVL_OBS, 1));
    rows.push_back(mk(bcts_pkg::OP_OBSERVE, '1, '1, 1, '1, 1, 16'd0, bcts_pkg::LVL_OBS, 0));
    rows.push_back(mk(bcts_pkg::OP_SCORE, '1, '1, 1, '1, 1, 16'd0, bcts_pkg::LVL_TRI, 0));
    rows.push_back(mk(bcts_pkg::OP_OBSERVE, '1, 0, 1, 1, 1, 16'd0, bcts_pkg::LVL_OBS, 0));
    rows.push_back(mk(bcts_pkg::OP_SCORE, '1, 5, 1, '1, 0, 0, 0, 0));
    rows.push_back(mk(bcts_pkg::OP_SCORE, 7, 0, 1, 1, 0, 0, 0, 0));
    rows.push_back(mk(bcts_pkg::OP_OBSERVE, 1, 1, 1, 1, 0, 0, 0, 0));
    rows.push_back(mk(bcts_pkg::OP_OBSERVE, 1, 1, 1, 2, 0, 0, 0, 0));
    rows.push_back(mk(bcts_pkg::OP_OBSERVE, 1, 1, 1, 2, 0, 0, 0, 0));
    rows.push_back(mk(bcts_pkg::OP_SCORE, 1, 1, 1, 2, 0, 0, 0, 0));
    rows.push_back(mk(bcts_pkg::OP_SCORE, 1, 1, 0, 2, 1,
                      bcts_pkg::LOG_INVALID, bcts_pkg::LVL_INV, 0));
    rows.push_back(mk(bcts_pkg::OP_SCORE, 1, 32'h8000_0000, 1, 2, 0, 0, 0, 0));
    rows.push_back(mk(bcts_pkg::OP_SCORE, 9, 1, 1, 2, 0, 0, 0, 0));
    foreach (rows[i]) send(rows[i].q, rows[i].typed, rows[i].r);

    // Key pools shared by the random phases.
    src_pool = '{32'd1, 32'hFFFF_FFFF, 32'h8000_0000, $urandom | 1, $urandom | 1,
                 $urandom | 1, $urandom | 1, $urandom | 1};
    evt_pool = '{32'd0, 32'hFFFF_FFFF, 32'h0000_0001, $urandom, $urandom,
                 $urandom, $urandom, $urandom};
    tgt_pool = '{32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, $urandom | 1, $urandom | 1,
                 $urandom | 1, $urandom | 1, $urandom | 1};

    // Pool traffic under several register settings.
    set_phase(32'd0, 16'hFFFF);
    repeat (60) send(rand_query(0, 40), 0, '0);
    set_phase(32'd3, 16'd26214);
    repeat (60) send(rand_query(0, 50), 0, '0);
    set_phase(32'd2, 16'd0);
    repeat (40) send(rand_query(0, 60), 0, '0);

    // Fresh keys until the tables are full, with pool scores mixed in.
    set_phase(32'd1, 16'd26214);
    repeat (260) begin
      if ($urandom_range(9) == 0) send(rand_query(0, 100), 0, '0);
      else send(rand_query(1, 0), 0, '0);
    end

    // Traffic against full tables, floor at its maximum and then at one.
    set_phase(32'hFFFF_FFFF, 16'd1);
    repeat (40) send(rand_query($urandom_range(3) == 0, 50), 0, '0);
    set_phase(32'd1, 16'd40000);
    repeat (90) send(rand_query($urandom_range(3) == 0, 50), 0, '0);

    wait (expected_scores.size() == 0);
    repeat (200) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/bcts_pkg.sv
hw/rtl/bcts_log2.sv
hw/rtl/bcts_dpath.sv
hw/rtl/bcts_ctrl.sv
hw/rtl/backoff_count_table_scorer_top.sv
test/backoff_count_table_scorer_top_test.sv
